[rtl/bud_pkg.sv]
// ----------------------------------------------------------------------------
// bud_pkg
// Types and constants for the byte unstuffing deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package bud_pkg;

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h7D;
	localparam logic [7:0]  ESC_XOR   = 8'h20;
	localparam logic [10:0] MIN_FRAME = 11'd3;
	localparam logic [10:0] OVERHEAD  = 11'd5;
	localparam logic [10:0] MAX_FRAME = 11'd1024;
	localparam logic [10:0] CAP_RESET = 11'd700;

	typedef enum logic [1:0] {
		MODE_WAIT   = 2'd0,
		MODE_ACCEPT = 2'd1,
		MODE_ESCAPE = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		KIND_DATA     = 3'd0,
		KIND_GOOD     = 3'd1,
		KIND_BAD      = 3'd2,
		KIND_SHORT    = 3'd3,
		KIND_OVERFLOW = 3'd4
	} kind_t;

endpackage

`default_nettype wire

[rtl/byte_unstuffing_deframer.sv]
// ----------------------------------------------------------------------------
// byte_unstuffing_deframer
// Flag-delimited deframer with escape removal and length field check.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata[7:0] rx_byte
//  m_axis    | out       | tuser[2:0] kind; tdata data, position, frame_length
//  cfg       | in        | cfg_wdata[10:0] frame_capacity, written on cfg_we
//
//  one byte per cycle: input register, single pass of decode, result register
//  arst_n clears the mode, count and length bytes and sets capacity (700)
//  a stall on m_axis holds the result and the input register behind it
// ----------------------------------------------------------------------------
`default_nettype none

module byte_unstuffing_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // data, position, frame_length, zero pad
	output logic [2:0]       m_axis_tuser    // kind
);

	logic [10:0]     cap_q;
	logic            valid_s1;
	logic [7:0]      byte_s1;
	bud_pkg::mode_t  mode_q, mode_d;
	logic [10:0]     count_q, count_d;
	logic [7:0]      len_lo_q, len_lo_d, len_hi_q, len_hi_d;
	logic            out_valid_q;
	bud_pkg::kind_t  out_kind_q;
	logic [7:0]      out_data_q;
	logic [9:0]      out_pos_q;
	logic [10:0]     out_flen_q;
	logic            advance;
	logic            emit;
	bud_pkg::kind_t  kind_d;
	logic [7:0]      data_d;
	logic [9:0]      pos_d;
	logic [10:0]     flen_d;
	logic [7:0]      store_b;
	logic [10:0]     count_inc;
	logic [15:0]     len_field;
	logic [15:0]     len_expect;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// capacity clamped once at write time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bud_pkg::CAP_RESET;
		end else if (cfg_we) begin
			if (cfg_wdata < bud_pkg::OVERHEAD) begin
				cap_q <= bud_pkg::OVERHEAD;
			end else if (cfg_wdata > bud_pkg::MAX_FRAME) begin
				cap_q <= bud_pkg::MAX_FRAME;
			end else begin
				cap_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	assign store_b    = (mode_q == bud_pkg::MODE_ESCAPE) ? (byte_s1 ^ bud_pkg::ESC_XOR) : byte_s1;
	assign count_inc  = count_q + 11'd1;
	assign len_field  = {len_hi_q, len_lo_q};
	assign len_expect = {5'd0, count_q} - {5'd0, bud_pkg::OVERHEAD};

	always_comb begin
		mode_d   = mode_q;
		count_d  = count_q;
		len_lo_d = len_lo_q;
		len_hi_d = len_hi_q;
		emit     = 1'b0;
		kind_d   = bud_pkg::KIND_DATA;
		data_d   = 8'd0;
		pos_d    = 10'd0;
		flen_d   = 11'd0;
		if ((mode_q == bud_pkg::MODE_ACCEPT) && (byte_s1 == bud_pkg::FLAG_BYTE)) begin
			emit    = 1'b1;
			flen_d  = count_q;
			count_d = 11'd0;
			if (count_q < bud_pkg::MIN_FRAME) begin
				kind_d = bud_pkg::KIND_SHORT;
			end else if ((count_q >= bud_pkg::OVERHEAD) && (len_field == len_expect)) begin
				kind_d = bud_pkg::KIND_GOOD;
			end else begin
				kind_d = bud_pkg::KIND_BAD;
			end
		end else if ((mode_q == bud_pkg::MODE_ACCEPT) && (byte_s1 == bud_pkg::ESC_BYTE)) begin
			mode_d = bud_pkg::MODE_ESCAPE;
		end else if ((mode_q == bud_pkg::MODE_ACCEPT) || (mode_q == bud_pkg::MODE_ESCAPE)) begin
			emit   = 1'b1;
			data_d = store_b;
			pos_d  = count_q[9:0];
			if (count_q == 11'd1) begin
				len_lo_d = store_b;
			end
			if (count_q == 11'd2) begin
				len_hi_d = store_b;
			end
			if (count_inc >= cap_q) begin
				kind_d  = bud_pkg::KIND_OVERFLOW;
				flen_d  = count_inc;
				count_d = 11'd0;
				mode_d  = bud_pkg::MODE_WAIT;
			end else begin
				count_d = count_inc;
				mode_d  = bud_pkg::MODE_ACCEPT;
			end
		end else begin
			count_d = 11'd0;
			mode_d  = (byte_s1 == bud_pkg::FLAG_BYTE) ? bud_pkg::MODE_ACCEPT : bud_pkg::MODE_WAIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= bud_pkg::MODE_WAIT;
			count_q  <= 11'd0;
			len_lo_q <= 8'd0;
			len_hi_q <= 8'd0;
		end else if (advance) begin
			mode_q   <= mode_d;
			count_q  <= count_d;
			len_lo_q <= len_lo_d;
			len_hi_q <= len_hi_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_kind_q <= kind_d;
			out_data_q <= data_d;
			out_pos_q  <= pos_d;
			out_flen_q <= flen_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {3'd0, out_flen_q, out_pos_q, out_data_q};

	a_good_len : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q == bud_pkg::KIND_GOOD)) |-> (out_flen_q >= bud_pkg::OVERHEAD))
		else $error("good frame shorter than header");

	a_end_no_data : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q != bud_pkg::KIND_DATA) && (out_kind_q != bud_pkg::KIND_OVERFLOW))
		|-> ((out_data_q == 8'd0) && (out_pos_q == 10'd0)))
		else $error("frame end result carries data");

	a_ovf_cap : assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && (kind_d == bud_pkg::KIND_OVERFLOW)) |=> (count_q == 11'd0)
		&& (mode_q == bud_pkg::MODE_WAIT))
		else $error("overflow did not return to waiting");

endmodule

`default_nettype wire

[sim/byte_unstuffing_deframer_tb.sv]
// ----------------------------------------------------------------------------
// byte_unstuffing_deframer_tb
// Self-checking bench for the flag-delimited deframer. Streams hand-picked and
// random byte sequences (framed, escaped, broken and noisy) at several capacity
// settings. A scoreboard predicts every result and checks it against m_axis.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_unstuffing_deframer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		bud_pkg::kind_t kind;
		logic [7:0]     data;
		logic [9:0]     pos;
		logic [10:0]    flen;
	} deframe_event_t;

	class deframe_scoreboard;
		bud_pkg::mode_t mode;
		logic [10:0]    count;
		logic [10:0]    capacity;
		logic [7:0]     len_lo;
		logic [7:0]     len_hi;
		deframe_event_t pending_events[$];
		int             errors;
		int             kind_seen[5];

		function new();
			mode     = bud_pkg::MODE_WAIT;
			count    = '0;
			capacity = bud_pkg::CAP_RESET;
			len_lo   = '0;
			len_hi   = '0;
			errors   = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
		endfunction

		function void set_capacity(logic [10:0] value);
			capacity = value;
		endfunction

		function int pending();
			return pending_events.size();
		endfunction

		function void push_event(bud_pkg::kind_t k, logic [7:0] d, logic [9:0] p,
				logic [10:0] f);
			deframe_event_t ev;
			ev.kind = k;
			ev.data = d;
			ev.pos  = p;
			ev.flen = f;
			pending_events.push_back(ev);
		endfunction

		function void store_byte(logic [7:0] b);
			logic [10:0] pos;
			int          limit;
			pos   = count;
			limit = int'(capacity);
			if (limit < int'(bud_pkg::OVERHEAD)) limit = int'(bud_pkg::OVERHEAD);
			if (limit > int'(bud_pkg::MAX_FRAME)) limit = int'(bud_pkg::MAX_FRAME);
			if (pos == 11'd1) len_lo = b;
			if (pos == 11'd2) len_hi = b;
			count = count + 11'd1;
			mode  = bud_pkg::MODE_ACCEPT;
			if (int'(count) >= limit) begin
				push_event(bud_pkg::KIND_OVERFLOW, b, pos[9:0], count);
				count = '0;
				mode  = bud_pkg::MODE_WAIT;
			end else begin
				push_event(bud_pkg::KIND_DATA, b, pos[9:0], 11'd0);
			end
		endfunction

		// predict the outcome of one accepted rx byte
		function void note_rx_byte(logic [7:0] b);
			logic [15:0] len_field;
			case (mode)
				bud_pkg::MODE_ACCEPT: begin
					if (b == bud_pkg::FLAG_BYTE) begin
						if (count >= bud_pkg::MIN_FRAME) begin
							len_field = {len_hi, len_lo};
							if (count >= bud_pkg::OVERHEAD
									&& len_field == 16'(count - bud_pkg::OVERHEAD))
								push_event(bud_pkg::KIND_GOOD, 8'd0, 10'd0, count);
							else
								push_event(bud_pkg::KIND_BAD, 8'd0, 10'd0, count);
						end else begin
							push_event(bud_pkg::KIND_SHORT, 8'd0, 10'd0, count);
						end
						count = '0;
					end else if (b == bud_pkg::ESC_BYTE) begin
						mode = bud_pkg::MODE_ESCAPE;
					end else begin
						store_byte(b);
					end
				end
				bud_pkg::MODE_ESCAPE: store_byte(b ^ bud_pkg::ESC_XOR);
				default: begin
					mode  = (b == bud_pkg::FLAG_BYTE) ? bud_pkg::MODE_ACCEPT
						: bud_pkg::MODE_WAIT;
					count = '0;
				end
			endcase
		endfunction

		function void check_result(logic [2:0] k, logic [7:0] d, logic [9:0] p,
				logic [10:0] f);
			deframe_event_t ev;
			if (pending_events.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: kind %0d data %02h pos %0d len %0d",
						k, d, p, f);
				return;
			end
			ev = pending_events.pop_front();
			if (k < 3'd5) kind_seen[k]++;
			if (k != ev.kind || d != ev.data || p != ev.pos || f != ev.flen) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp kind %0d data %02h pos %0d len %0d, %s",
						ev.kind, ev.data, ev.pos, ev.flen,
						$sformatf("got kind %0d data %02h pos %0d len %0d",
							k, d, p, f));
			end
		endfunction
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [10:0] cfg_wdata     = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	deframe_scoreboard sb = new();

	int bytes_sent  = 0;
	int burst_left  = 0;
	int gap_max     = 0;
	int stall_style = 0;
	int rx_cycle    = 0;

	byte_unstuffing_deframer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),    // rx_byte
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),    // data, position, frame_length, zero pad
		.m_axis_tuser  (m_axis_tuser)     // kind
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("timeout with %0d results still pending", sb.pending());
		$display("FAILURE");
		$finish;
	end

	// receiver stall pattern, in one of four randomly chosen styles
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 300 == 0) stall_style = $urandom_range(0, 3);
		case (stall_style)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= ((rx_cycle % 7) >= 2);
			default: m_axis_tready <= ((rx_cycle % 40) < 6);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_rx_byte(s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[17:8],
				m_axis_tdata[28:18]);
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// escape bytes that need it, and now and then one that does not
	task automatic send_payload_byte(input logic [7:0] v);
		if (v == bud_pkg::FLAG_BYTE || v == bud_pkg::ESC_BYTE
				|| $urandom_range(0, 15) == 0) begin
			send_byte(bud_pkg::ESC_BYTE);
			send_byte(v ^ bud_pkg::ESC_XOR);
		end else begin
			send_byte(v);
		end
	endtask

	// frame body followed by the closing flag
	task automatic send_frame(input int len);
		logic [15:0] len_field;
		logic [7:0]  v;
		if (len >= 5 && $urandom_range(0, 9) < 6)
			len_field = 16'(len - 5);
		else
			len_field = 16'($urandom_range(0, 65535));
		for (int i = 0; i < len; i++) begin
			if (i == 1)
				v = len_field[7:0];
			else if (i == 2)
				v = len_field[15:8];
			else
				v = 8'($urandom_range(0, 255));
			send_payload_byte(v);
		end
		send_byte(bud_pkg::FLAG_BYTE);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [10:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_capacity(value);
	endtask

	task automatic run_traffic(input int n_bytes, input int max_len);
		int start;
		int pick;
		start   = bytes_sent;
		gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
		send_byte(bud_pkg::FLAG_BYTE);
		while (bytes_sent - start < n_bytes) begin
			pick = $urandom_range(0, 99);
			if (pick < 78) begin
				if ($urandom_range(0, 1) == 0)
					send_frame($urandom_range(0, 8));
				else
					send_frame($urandom_range(0, max_len));
			end else if (pick < 88) begin
				// line noise, then resync on a flag
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
				send_byte(bud_pkg::FLAG_BYTE);
			end else begin
				// broken frame: escape runs into a flag or another escape
				repeat ($urandom_range(0, 4)) send_payload_byte(8'($urandom_range(0, 255)));
				send_byte(bud_pkg::ESC_BYTE);
				if ($urandom_range(0, 1) == 0) send_byte(bud_pkg::ESC_BYTE);
				send_byte(bud_pkg::FLAG_BYTE);
				send_byte(bud_pkg::FLAG_BYTE);
			end
			if ($urandom_range(0, 7) == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
		end
	endtask

	initial begin
		logic [7:0]  opening[$];
		logic [10:0] caps[$];

		opening = '{
			8'h7D, 8'h00, 8'hFF,                       // ignored while waiting
			8'h7E, 8'h7E,                              // empty frame
			8'hAA, 8'h7E,                              // one byte
			8'h11, 8'h22, 8'h7E,                       // two bytes
			8'h01, 8'h00, 8'h00, 8'h7E,                // three bytes
			8'h00, 8'h00, 8'h00, 8'h00, 8'h7E,         // four bytes
			8'hC3, 8'h00, 8'h00, 8'h7D, 8'h5E, 8'hFF, 8'h7E, // five, length matches
			8'h7D, 8'h5D, 8'h7D, 8'h7E, 8'h01, 8'h7E   // escaped escape, then escape before a flag
		};
		caps = '{11'd0, 11'd4, 11'd5, 11'd6, 11'd2047, 11'd1024};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset capacity first
		foreach (opening[i]) send_byte(opening[i]);
		drain();

		foreach (caps[i]) begin
			write_capacity(caps[i]);
			run_traffic(caps[i] > 11'd100 ? 20 : 30, caps[i] > 11'd100 ? 30 : 12);
		end

		// one frame long enough to hit the largest capacity
		write_capacity(11'd1025);
		gap_max = 4;
		send_byte(bud_pkg::FLAG_BYTE);
		send_frame(1030);
		run_traffic(20, 20);

		repeat (3) begin
			write_capacity(11'($urandom_range(8, 48)));
			run_traffic(30, 60);
		end

		write_capacity(bud_pkg::CAP_RESET);
		run_traffic(20, 40);

		drain();
		$display("sent %0d bytes; data %0d, good %0d, bad length %0d, short %0d, overflow %0d",
			bytes_sent, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2],
			sb.kind_seen[3], sb.kind_seen[4]);
		$display("capacities covered: clamped low and high, edges 5/6/1024, random small");
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
